[rtl/dda_pkg.sv]
package dda_pkg;

	// Fixed field widths of the pixel item and the width register
	localparam int ADDR_BITS  = 24;
	localparam int COLOR_BITS = 32;
	localparam int WIDTH_BITS = 13;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd640;

	// Request item kinds
	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture endpoints and colour
		logic axis;      // pick the major axis
		logic order;     // order endpoints, start the divide
		logic div_step;  // one quotient bit
		logic finish;    // sign the quotient into the increment
		logic emit;      // register the current pixel
		logic advance;   // move to the next pixel
	} dda_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last;      // current pixel is the line's final one
	} dda_sts_t;

endpackage

[rtl/dda_req_if.sv]
interface dda_req_if
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();

	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;
	logic [COLOR_BITS-1:0] pen_color;

	modport source (
		output valid, action, x_start, y_start, x_end, y_end, pen_color,
		input  ready
	);

	modport sink (
		input  valid, action, x_start, y_start, x_end, y_end, pen_color,
		output ready
	);

endinterface

[rtl/dda_pix_if.sv]
interface dda_pix_if
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();

	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [ADDR_BITS-1:0]  pixel_address;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		output ready
	);

endinterface

[rtl/dda_line_walker_top.sv]
// Channel   Dir   Item
// --------  ----  ------------------------------------------------------------
// req       in    action, x_start, y_start, x_end, y_end, pen_color
// pix       out   pixel_x, pixel_y, pixel_address, pixel_color, last_pixel
// cfg       in    cfg_we / cfg_data: frame width, written on any edge with cfg_we
//
// A step item needs no set-up; one pixel per cycle while pix keeps up.
// A start item runs capture, axis pick, ordering, FRACTION_BITS + 1 radix-2
// divide steps and sign fix-up, in that order.
// arst_n clears the sequencer, the line flag and the output valid; width is 640.
// req.ready is low during line set-up and while an unaccepted pixel is held.
module dda_line_walker_top
	import dda_pkg::*;
#(
	parameter int COORD_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dda_req_if.sink               req,
	dda_pix_if.source             pix,
	input  logic                  cfg_we,
	input  logic [WIDTH_BITS-1:0] cfg_data
);

	dda_cmd_t cmd;
	dda_sts_t sts;

	dda_ctrl #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.out_ready (pix.ready),
		.out_valid (pix.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	dda_dp #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.x_start       (req.x_start),
		.y_start       (req.y_start),
		.x_end         (req.x_end),
		.y_end         (req.y_end),
		.pen_color     (req.pen_color),
		.pixel_x       (pix.pixel_x),
		.pixel_y       (pix.pixel_y),
		.pixel_address (pix.pixel_address),
		.pixel_color   (pix.pixel_color),
		.last_pixel    (pix.last_pixel)
	);

	// A start item blocks the request side for set-up
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.action == ACT_START) |=> !req.ready)
		else $error("request taken during line set-up");

	// A held pixel is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && !pix.ready) |-> !cmd.emit)
		else $error("pending pixel overwritten");

	// The walk only moves on an emitted pixel that is not the last
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (cmd.emit && !sts.last))
		else $error("walk advanced past the line end");

	// Endpoints are captured only from an accepted start item
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (req.valid && req.ready && req.action == ACT_START))
		else $error("line loaded without a start item");

endmodule

[rtl/dda_div.sv]
module dda_div
	import dda_pkg::*;
#(
	parameter int COORD_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     init,
	input  logic                     step,
	input  logic [COORD_BITS-1:0]    num,
	input  logic [COORD_BITS-1:0]    den,
	output logic [FRACTION_BITS:0]   quo
);

	// Restoring radix-2 divide of num * 2^F by den, with num <= den.
	// First step gives the integer bit, then F fraction bits.
	logic [COORD_BITS:0]   rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [FRACTION_BITS:0] quo_q;

	logic [COORD_BITS+1:0] diff;
	logic                  ge;
	logic [COORD_BITS:0]   rem_next;

	// Trial subtract
	always_comb begin
		diff     = {1'b0, rem_q} - {2'b00, den_q};
		ge       = !diff[COORD_BITS+1];
		rem_next = ge ? diff[COORD_BITS:0] : rem_q;
	end

	// Remainder stays below den, so the shifted value fits one extra bit
	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[FRACTION_BITS-1:0], ge};
			rem_q <= {rem_next[COORD_BITS-1:0], 1'b0};
		end
	end

	assign quo = quo_q;

endmodule

[rtl/dda_dp.sv]
module dda_dp
	import dda_pkg::*;
#(
	parameter int COORD_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dda_cmd_t              cmd,
	output dda_sts_t              sts,
	input  logic                  cfg_we,
	input  logic [WIDTH_BITS-1:0] cfg_data,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] pen_color,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [ADDR_BITS-1:0]  pixel_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	localparam int ACC_BITS  = COORD_BITS + FRACTION_BITS;
	localparam int PROD_BITS = COORD_BITS + WIDTH_BITS;

	logic [WIDTH_BITS-1:0] width_q;

	logic [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [COLOR_BITS-1:0] color_q;

	logic                  x_major_q;
	logic [COORD_BITS-1:0] maj_a_q, maj_b_q, min_a_q, min_b_q;

	logic [COORD_BITS-1:0] pos_q, lim_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic                  neg_q, zero_q;
	logic signed [FRACTION_BITS+1:0] inc_q;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COLOR_BITS-1:0] pcol_q;
	logic                  last_q;

	// Axis selection
	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] adx, ady;
	logic                  x_major;

	always_comb begin
		dx      = {1'b0, xb_q} - {1'b0, xa_q};
		dy      = {1'b0, yb_q} - {1'b0, ya_q};
		adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		x_major = adx > ady;
	end

	// Endpoint ordering and deltas
	logic                  swap;
	logic [COORD_BITS-1:0] lo_maj, hi_maj, min_from, min_to, dmaj, dmin_abs;
	logic                  dmin_neg;

	always_comb begin
		swap     = maj_a_q > maj_b_q;
		lo_maj   = swap ? maj_b_q : maj_a_q;
		hi_maj   = swap ? maj_a_q : maj_b_q;
		min_from = swap ? min_b_q : min_a_q;
		min_to   = swap ? min_a_q : min_b_q;
		dmaj     = hi_maj - lo_maj;
		dmin_neg = min_to < min_from;
		dmin_abs = dmin_neg ? (min_from - min_to) : (min_to - min_from);
	end

	logic [FRACTION_BITS:0] quo;

	dda_div #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk  (clk),
		.init (cmd.order),
		.step (cmd.div_step),
		.num  (dmin_abs),
		.den  (dmaj),
		.quo  (quo)
	);

	// Current pixel and its address
	logic [COORD_BITS-1:0] minor, cur_x, cur_y;
	logic [PROD_BITS-1:0]  prod;
	logic [ADDR_BITS-1:0]  addr;

	always_comb begin
		minor = acc_q[ACC_BITS-1:FRACTION_BITS];
		cur_x = x_major_q ? pos_q : minor;
		cur_y = x_major_q ? minor : pos_q;
		prod  = cur_y * width_q;
		addr  = ADDR_BITS'(prod) + ADDR_BITS'(cur_x);
	end

	assign sts.last = (pos_q == lim_q);

	// Frame width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	// Line set-up registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xa_q    <= x_start;
			ya_q    <= y_start;
			xb_q    <= x_end;
			yb_q    <= y_end;
			color_q <= pen_color;
		end
		if (cmd.axis) begin
			x_major_q <= x_major;
			maj_a_q   <= x_major ? xa_q : ya_q;
			maj_b_q   <= x_major ? xb_q : yb_q;
			min_a_q   <= x_major ? ya_q : xa_q;
			min_b_q   <= x_major ? yb_q : xb_q;
		end
		if (cmd.finish) begin
			if (zero_q) begin
				inc_q <= '0;
			end else if (neg_q) begin
				inc_q <= -$signed({1'b0, quo});
			end else begin
				inc_q <= $signed({1'b0, quo});
			end
		end
	end

	// Walk state: loaded on ordering, moved on each pixel but the last
	always_ff @(posedge clk) begin
		if (cmd.order) begin
			pos_q  <= lo_maj;
			lim_q  <= hi_maj;
			acc_q  <= {min_from, {FRACTION_BITS{1'b0}}};
			neg_q  <= dmin_neg;
			zero_q <= (dmaj == '0);
		end else if (cmd.advance) begin
			pos_q <= pos_q + 1'b1;
			acc_q <= acc_q + ACC_BITS'(inc_q);
		end
	end

	// Output item register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			px_q   <= cur_x;
			py_q   <= cur_y;
			addr_q <= addr;
			pcol_q <= color_q;
			last_q <= sts.last;
		end
	end

	assign pixel_x       = px_q;
	assign pixel_y       = py_q;
	assign pixel_address = addr_q;
	assign pixel_color   = pcol_q;
	assign last_pixel    = last_q;

endmodule

[rtl/dda_ctrl.sv]
module dda_ctrl
	import dda_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_action,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	input  dda_sts_t sts,
	output dda_cmd_t cmd
);

	localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRACTION_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_AXIS,
		S_ORDER,
		S_DIV,
		S_FIN
	} state_t;

	state_t              state_q;
	logic                active_q;
	logic                out_valid_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic accept, step;

	// Handshake and commands
	always_comb begin
		in_ready     = (state_q == S_IDLE) && (!out_valid_q || out_ready);
		accept       = in_valid && in_ready;
		step         = accept && (in_action == ACT_STEP);
		cmd.load     = accept && (in_action == ACT_START);
		cmd.axis     = (state_q == S_AXIS);
		cmd.order    = (state_q == S_ORDER);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_FIN);
		cmd.emit     = step && active_q;
		cmd.advance  = cmd.emit && !sts.last;
	end

	assign out_valid = out_valid_q;

	// Sequencer, line flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						active_q <= 1'b0;
						state_q  <= S_AXIS;
					end else if (cmd.emit && sts.last) begin
						active_q <= 1'b0;
					end
				end
				S_AXIS: begin
					state_q <= S_ORDER;
				end
				S_ORDER: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					active_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
